/* hdl/fbpc_pkg.sv */
// ----------------------------------------------------------------------------
// fbpc_pkg
// Shared types and constants of the feather band point classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpc_pkg;

    localparam int FBPC_MAX_BANDS = 16;

    localparam int FBPC_VAL_W   = 24;   // unsigned Q12.12 values
    localparam int FBPC_SLOPE_W = 16;   // Q4.12 slopes and tangent
    localparam int FBPC_CNT_W   = 5;    // band count register
    localparam int FBPC_FRAC    = 12;
    localparam int FBPC_OFF_W   = FBPC_VAL_W + FBPC_FRAC;
    localparam int FBPC_IDX_W   = 3;

    // configuration register indexes
    typedef enum logic [FBPC_IDX_W-1:0] {
        REG_COLUMN_RADIUS = 3'd0,
        REG_WIDEN_TAN     = 3'd1,
        REG_WIDEN_ENABLE  = 3'd2,
        REG_FEATHER_START = 3'd3,
        REG_BAND_SPACING  = 3'd4,
        REG_UPPER_SLOPE   = 3'd5,
        REG_LOWER_SLOPE   = 3'd6,
        REG_BAND_COUNT    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [FBPC_VAL_W-1:0]          column_radius;
        logic [FBPC_SLOPE_W-1:0]        widen_tan;
        logic                           widen_enable;
        logic [FBPC_VAL_W-1:0]          feather_start;
        logic [FBPC_VAL_W-1:0]          band_spacing;
        logic signed [FBPC_SLOPE_W-1:0] upper_slope;
        logic signed [FBPC_SLOPE_W-1:0] lower_slope;
        logic [FBPC_CNT_W-1:0]          band_count;
    } cfg_t;

    // operand choice of the shared multiplier
    typedef enum logic [1:0] {
        MUL_CONE  = 2'd0,
        MUL_UPPER = 2'd1,
        MUL_LOWER = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;     // capture the input point
        logic     init;     // form offset and band distance
        logic     mul_en;   // register a product
        mul_sel_t mul_sel;
        logic     step_d;   // move band distance down by one spacing
    } ctrl_t;

    typedef struct packed {
        logic core_in;      // radius below column radius
        logic off_lt_prod;  // offset below registered product
        logic prod_lt_off;  // registered product below offset
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORE,
        S_CONE,
        S_CONE_CHK,
        S_UP,
        S_LO,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* hdl/fbpc_datapath.sv */
// ----------------------------------------------------------------------------
// fbpc_datapath
// Point registers, running band distance and the shared multiply-compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpc_datapath #(
    parameter int MAX_BANDS = fbpc_pkg::FBPC_MAX_BANDS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire fbpc_pkg::ctrl_t                 ctrl,
    input  wire fbpc_pkg::cfg_t                  cfg,
    input  wire [fbpc_pkg::FBPC_VAL_W-1:0]       in_radius,
    input  wire [fbpc_pkg::FBPC_VAL_W-1:0]       in_height,
    output fbpc_pkg::status_t                    status
);
    import fbpc_pkg::*;

    // band distance must hold height minus start minus every spacing step
    localparam int DW = FBPC_VAL_W + 2 + $clog2(MAX_BANDS + 1);
    localparam int AW = FBPC_SLOPE_W + 1;
    localparam int PW = AW + DW;

    logic [FBPC_VAL_W-1:0]  r_reg;
    logic [FBPC_VAL_W-1:0]  h_reg;
    logic [FBPC_OFF_W-1:0]  off_reg;
    logic signed [DW-1:0]   d_reg;
    logic signed [PW-1:0]   prod_reg;

    logic signed [AW-1:0]   mul_a;
    logic signed [DW-1:0]   mul_b;
    logic signed [DW-1:0]   d_dec;
    logic signed [DW-1:0]   d_init;
    logic [FBPC_VAL_W-1:0]  r_diff;
    logic signed [PW-1:0]   off_ext;
    logic signed [PW-1:0]   prod_next;

    assign d_dec  = d_reg - signed'(DW'(cfg.band_spacing));
    assign d_init = signed'(DW'(h_reg)) - signed'(DW'(cfg.feather_start));
    assign r_diff = r_reg - cfg.column_radius;

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_CONE:
            begin
                mul_a = signed'({1'b0, cfg.widen_tan});
                mul_b = signed'(DW'(h_reg));
            end
            MUL_UPPER:
            begin
                mul_a = AW'(cfg.upper_slope);
                mul_b = d_reg;
            end
            MUL_LOWER:
            begin
                mul_a = AW'(cfg.lower_slope);
                mul_b = d_dec;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg    <= '0;
            h_reg    <= '0;
            off_reg  <= '0;
            d_reg    <= '0;
            prod_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                r_reg <= in_radius;
                h_reg <= in_height;
            end
            if (ctrl.init)
            begin
                off_reg <= {r_diff, {FBPC_FRAC{1'b0}}};
                d_reg   <= d_init;
            end
            else if (ctrl.step_d)
            begin
                d_reg <= d_dec;
            end
            if (ctrl.mul_en)
            begin
                prod_reg <= prod_next;
            end
        end
    end

    // offset is never negative once the core test has failed
    assign off_ext = signed'(PW'(off_reg));

    assign status.core_in     = (r_reg < cfg.column_radius);
    assign status.off_lt_prod = (off_ext < prod_reg);
    assign status.prod_lt_off = (prod_reg < off_ext);

endmodule

`default_nettype wire

/* hdl/fbpc_ctrl.sv */
// ----------------------------------------------------------------------------
// fbpc_ctrl
// Sequencer: core test, cone test when widening is enabled, then two multiply steps per feather band.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpc_ctrl #(
    parameter int MAX_BANDS = fbpc_pkg::FBPC_MAX_BANDS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                widen_enable,
    input  wire [fbpc_pkg::FBPC_CNT_W-1:0]     band_count,
    input  wire fbpc_pkg::status_t             status,
    output fbpc_pkg::ctrl_t                    ctrl,
    input  wire                                out_free,
    output logic                               res_valid,
    output logic                               res
);
    import fbpc_pkg::*;

    localparam int IW = $clog2(MAX_BANDS + 1);

    state_t          state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   n_reg, n_next;
    logic            pend_reg, pend_next;
    logic            up_ok_reg, up_ok_next;
    logic            res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            up_ok_reg <= 1'b0;
            res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            up_ok_reg <= up_ok_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        pend_next    = pend_reg;
        up_ok_next   = up_ok_reg;
        res_next     = res_reg;
        ctrl         = '0;
        ctrl.mul_sel = MUL_CONE;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_CORE;
                end
            end
            S_CORE:
            begin
                ctrl.init = 1'b1;
                idx_next  = '0;
                pend_next = 1'b0;
                if (32'(band_count) > MAX_BANDS)
                    n_next = IW'(MAX_BANDS);
                else
                    n_next = IW'(band_count);
                if (status.core_in)
                begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (widen_enable)
                    state_next = S_CONE;
                else
                    state_next = S_UP;
            end
            S_CONE:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_CONE;
                state_next   = S_CONE_CHK;
            end
            S_CONE_CHK:
            begin
                if (status.off_lt_prod)
                begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_UP;
            end
            S_UP:
            begin
                // check the lower edge of the previous band while issuing the next
                if (pend_reg && up_ok_reg && !status.off_lt_prod)
                begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (idx_reg == n_reg)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.mul_en  = 1'b1;
                    ctrl.mul_sel = MUL_UPPER;
                    idx_next     = idx_reg + 1'b1;
                    state_next   = S_LO;
                end
            end
            S_LO:
            begin
                up_ok_next   = !status.prod_lt_off;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_LOWER;
                ctrl.step_d  = 1'b1;
                pend_next    = 1'b1;
                state_next   = S_UP;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* hdl/feather_band_point_classifier_core.sv */
// ----------------------------------------------------------------------------
// feather_band_point_classifier_core
// Decides whether a point (radius, height) lies inside a columnar grain.
// ----------------------------------------------------------------------------
// One point is classified at a time on a single shared 17 x 31 bit multiplier
// followed by a compare on the registered product. A point goes through the
// core radius test, the widening cone (a multiply, then a check) when enabled,
// then an upper and a lower multiply step per feather band and a last check,
// and then hands the result to the output register; it finishes early when a
// test already places the point inside. s_tready is high only between points;
// the result register lets the next point start while the previous result is
// still waiting downstream. Configuration writes are always accepted and take
// effect at once.
`default_nettype none

module feather_band_point_classifier_core #(
    parameter int MAX_BANDS = fbpc_pkg::FBPC_MAX_BANDS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [47:0]                         s_tdata,   // radius[23:0], height[47:24]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [7:0]                         m_tdata,   // inside_res[0], zero pad
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [fbpc_pkg::FBPC_IDX_W-1:0]     cfg_index,
    input  wire [fbpc_pkg::FBPC_VAL_W-1:0]     cfg_data
);
    import fbpc_pkg::*;

    cfg_t    cfg_reg;
    ctrl_t   ctrl;
    status_t status;
    logic    out_free;
    logic    res_valid;
    logic    res;
    logic    m_tvalid_reg;
    logic    inside_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_COLUMN_RADIUS: cfg_reg.column_radius <= cfg_data;
                REG_WIDEN_TAN:     cfg_reg.widen_tan     <= cfg_data[FBPC_SLOPE_W-1:0];
                REG_WIDEN_ENABLE:  cfg_reg.widen_enable  <= cfg_data[0];
                REG_FEATHER_START: cfg_reg.feather_start <= cfg_data;
                REG_BAND_SPACING:  cfg_reg.band_spacing  <= cfg_data;
                REG_UPPER_SLOPE:   cfg_reg.upper_slope   <= cfg_data[FBPC_SLOPE_W-1:0];
                REG_LOWER_SLOPE:   cfg_reg.lower_slope   <= cfg_data[FBPC_SLOPE_W-1:0];
                REG_BAND_COUNT:    cfg_reg.band_count    <= cfg_data[FBPC_CNT_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    fbpc_ctrl #(
        .MAX_BANDS (MAX_BANDS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .widen_enable (cfg_reg.widen_enable),
        .band_count   (cfg_reg.band_count),
        .status       (status),
        .ctrl         (ctrl),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    fbpc_datapath #(
        .MAX_BANDS (MAX_BANDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .in_radius (s_tdata[23:0]),
        .in_height (s_tdata[47:24]),
        .status    (status)
    );

    // result register frees when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
            inside_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, inside_reg};

endmodule

`default_nettype wire
